// File: rtl/btrn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btrn_pkg
// Shared types and constants for the binary threshold recurrent network core.
// ----------------------------------------------------------------------------
package btrn_pkg;

  localparam int DEF_NUM_INPUTS  = 4;
  localparam int DEF_NUM_HIDDEN  = 8;
  localparam int DEF_NUM_OUTPUTS = 4;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int ACC_W   = 40;
  localparam int OUT_W   = 4;
  localparam int HID_W   = 8;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_I2H  = 3'd0,
    CMD_H2H  = 3'd1,
    CMD_H2O  = 3'd2,
    CMD_HTH  = 3'd3,
    CMD_OTH  = 3'd4,
    CMD_INP  = 3'd5,
    CMD_HBIT = 3'd6,
    CMD_STEP = 3'd7
  } cmd_t;

  // A classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_t                    cmd;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    bad;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/btrn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btrn_front
// Accepts commands, checks their indexes and places them in a short queue.
// ----------------------------------------------------------------------------
module btrn_front #(
  parameter int NUM_INPUTS  = btrn_pkg::DEF_NUM_INPUTS,
  parameter int NUM_HIDDEN  = btrn_pkg::DEF_NUM_HIDDEN,
  parameter int NUM_OUTPUTS = btrn_pkg::DEF_NUM_OUTPUTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [btrn_pkg::CMD_W-1:0]        cmd,
  input  wire logic [btrn_pkg::IDX_W-1:0]        row_index,
  input  wire logic [btrn_pkg::IDX_W-1:0]        col_index,
  input  wire logic signed [btrn_pkg::VAL_W-1:0] value,
  output logic                                   q_valid,
  input  wire logic                              q_ready,
  output btrn_pkg::item_t                        q_item
);
  import btrn_pkg::*;

  localparam int DEPTH = 2;

  item_t      buf_q [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push, pop;
  logic [4:0] row_x, col_x;

  // Classify the incoming command by its index range.
  always_comb begin
    row_x     = {1'b0, row_index};
    col_x     = {1'b0, col_index};
    cls.cmd   = cmd_t'(cmd);
    cls.row   = row_index;
    cls.col   = col_index;
    cls.value = value;
    case (cmd_t'(cmd))
      CMD_I2H: cls.bad = (row_x >= 5'(NUM_INPUTS)) || (col_x >= 5'(NUM_HIDDEN));
      CMD_H2H: cls.bad = (row_x >= 5'(NUM_HIDDEN)) || (col_x >= 5'(NUM_HIDDEN));
      CMD_H2O: cls.bad = (row_x >= 5'(NUM_HIDDEN)) || (col_x >= 5'(NUM_OUTPUTS));
      CMD_HTH, CMD_HBIT: cls.bad = row_x >= 5'(NUM_HIDDEN);
      CMD_OTH: cls.bad = row_x >= 5'(NUM_OUTPUTS);
      CMD_INP: cls.bad = row_x >= 5'(NUM_INPUTS);
      default: cls.bad = 1'b0;
    endcase
  end

  assign in_ready = (count != 2'(DEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_item   = buf_q[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Two-entry queue.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/btrn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btrn_back
// Executes commands: writes stores and runs the step with one shared
// multiply-accumulate unit, then holds the result in an output register.
// ----------------------------------------------------------------------------
module btrn_back #(
  parameter int NUM_INPUTS  = btrn_pkg::DEF_NUM_INPUTS,
  parameter int NUM_HIDDEN  = btrn_pkg::DEF_NUM_HIDDEN,
  parameter int NUM_OUTPUTS = btrn_pkg::DEF_NUM_OUTPUTS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire btrn_pkg::item_t           q_item,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [btrn_pkg::OUT_W-1:0]     output_bits,
  output logic [btrn_pkg::HID_W-1:0]     hidden_bits,
  output logic                           status
);
  import btrn_pkg::*;

  localparam int NI = NUM_INPUTS;
  localparam int NH = NUM_HIDDEN;
  localparam int NO = NUM_OUTPUTS;
  localparam int IW = (NI > 1) ? $clog2(NI) : 1;
  localparam int HW = (NH > 1) ? $clog2(NH) : 1;
  localparam int OW = (NO > 1) ? $clog2(NO) : 1;
  localparam int JW = (NH > NI) ? HW : IW;
  localparam int NW = (HW > OW) ? HW : OW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OUT  = 5'b00010,
    S_IN   = 5'b00100,
    S_HID  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Stores; the weight memories are read at one address per cycle.
  logic signed [VAL_W-1:0] mem_i2h [NI*NH];
  logic signed [VAL_W-1:0] mem_h2h [NH*NH];
  logic signed [VAL_W-1:0] mem_h2o [NH*NO];
  logic signed [VAL_W-1:0] hid_th  [NH];
  logic signed [VAL_W-1:0] out_th  [NO];
  logic signed [VAL_W-1:0] inp     [NI];
  logic [NH-1:0]           hid_st, old_hid, new_hid;
  logic [NO-1:0]           out_st, new_out;

  state_t                  state;
  logic [NW-1:0]           node;
  logic [JW-1:0]           j;
  logic                    rd_vld, rd_last, rd_bit;
  logic signed [VAL_W-1:0] rd_w, rd_x;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;
  logic                    rd_en, last_j;
  logic [HW+OW-1:0]        a_h2o;
  logic [IW+HW-1:0]        a_i2h;
  logic [2*HW-1:0]         a_h2h;
  logic                    fin_vld;

  // Node identity delayed to line up with the registered read.
  logic [NW-1:0]           node_d;
  logic                    out_d;
  logic signed [ACC_W-1:0] th_d;

  // Node decisions, registered when a node's sum is complete.
  logic [NW-1:0]           dec_node;
  logic                    dec_out;
  logic signed [ACC_W-1:0] dec_th;

  assign q_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    a_h2o  = (HW+OW)'(j) * (HW+OW)'(NO) + (HW+OW)'(node);
    a_i2h  = (IW+HW)'(j) * (IW+HW)'(NH) + (IW+HW)'(node);
    a_h2h  = (2*HW)'(j) * (2*HW)'(NH) + (2*HW)'(node);
    case (state)
      S_OUT: last_j = (32'(j) == NH - 1);
      S_IN:  last_j = (32'(j) == NI - 1);
      S_HID: last_j = (32'(j) == NH - 1);
      default: last_j = 1'b0;
    endcase
    rd_en = (state == S_OUT) || (state == S_IN) || (state == S_HID);
  end

  // Term formed from the registered read; hidden terms scaled by 256.
  always_comb begin
    term = '0;
    if (rd_vld) begin
      if (rd_bit) begin
        term = ACC_W'(rd_x) * ACC_W'(rd_w);
      end
    end
  end

  // Store writes, the read pipeline and the step sequencer.
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && !q_item.bad) begin
      case (q_item.cmd)
        CMD_I2H: mem_i2h[(IW+HW)'(q_item.row[IW-1:0]) * (IW+HW)'(NH)
                         + (IW+HW)'(q_item.col[HW-1:0])] <= q_item.value;
        CMD_H2H: mem_h2h[(2*HW)'(q_item.row[HW-1:0]) * (2*HW)'(NH)
                         + (2*HW)'(q_item.col[HW-1:0])] <= q_item.value;
        CMD_H2O: mem_h2o[(HW+OW)'(q_item.row[HW-1:0]) * (HW+OW)'(NO)
                         + (HW+OW)'(q_item.col[OW-1:0])] <= q_item.value;
        CMD_HTH: hid_th[q_item.row[HW-1:0]] <= q_item.value;
        CMD_OTH: out_th[q_item.row[OW-1:0]] <= q_item.value;
        default: ;
      endcase
    end
    case (state)
      S_OUT: begin
        rd_w <= mem_h2o[a_h2o];
        rd_x <= VAL_W'(1);
        rd_bit <= old_hid[j[HW-1:0]];
      end
      S_IN: begin
        rd_w <= mem_i2h[a_i2h];
        rd_x <= inp[j[IW-1:0]];
        rd_bit <= 1'b1;
      end
      default: begin
        rd_w <= mem_h2h[a_h2h];
        rd_x <= VAL_W'(256);
        rd_bit <= old_hid[j[HW-1:0]];
      end
    endcase
    if (rst) begin
      state     <= S_IDLE;
      hid_st    <= '1;
      out_st    <= '1;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      fin_vld   <= 1'b0;
      for (int k = 0; k < NI; k++) begin
        inp[k] <= '0;
      end
    end else begin
      rd_vld  <= rd_en;
      rd_last <= rd_en && last_j && !(state == S_IN);
      fin_vld <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            status <= q_item.bad;
            if (q_item.cmd == CMD_STEP) begin
              state   <= S_OUT;
              old_hid <= hid_st;
              node    <= '0;
              j       <= '0;
              acc     <= '0;
            end else begin
              if (!q_item.bad && q_item.cmd == CMD_INP) begin
                inp[q_item.row[IW-1:0]] <= q_item.value;
              end
              if (!q_item.bad && q_item.cmd == CMD_HBIT) begin
                hid_st[q_item.row[HW-1:0]] <= q_item.value[0];
              end
              out_valid <= 1'b1;
            end
          end
        end
        S_OUT, S_IN, S_HID: begin
          j <= last_j ? '0 : j + 1'b1;
          if (last_j) begin
            if (state == S_OUT) begin
              if (32'(node) == NO - 1) begin
                state <= S_IN;
                node  <= '0;
              end else begin
                node <= node + 1'b1;
              end
            end else if (state == S_IN) begin
              state <= S_HID;
            end else begin
              state <= S_IN;
              if (32'(node) == NH - 1) begin
                state <= S_DONE;
              end else begin
                node <= node + 1'b1;
              end
            end
          end
        end
        S_DONE: begin
          if (!rd_vld && !fin_vld) begin
            hid_st    <= new_hid;
            out_st    <= new_out;
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Accumulate; at the end of a node, compare and clear.
      if (rd_vld) begin
        if (rd_last) begin
          fin_vld <= 1'b1;
          acc     <= (fin_vld ? '0 : acc) + term;
        end else if (fin_vld) begin
          acc <= term;
        end else begin
          acc <= acc + term;
        end
      end else if (fin_vld) begin
        acc <= '0;
      end
    end
  end

  // Capture the node identity with its last term, decide in the following cycle.
  always_ff @(posedge clk) begin
    if (rd_last) begin
      dec_node <= node_d;
      dec_out  <= out_d;
      dec_th   <= th_d;
    end
    if (fin_vld) begin
      if (dec_out) begin
        new_out[dec_node[OW-1:0]] <= (acc > dec_th);
      end else begin
        new_hid[dec_node[HW-1:0]] <= (acc > dec_th);
      end
    end
  end

  always_ff @(posedge clk) begin
    node_d <= node;
    out_d  <= (state == S_OUT);
    th_d   <= (state == S_OUT) ? ACC_W'(out_th[node[OW-1:0]])
                               : ACC_W'(hid_th[node[HW-1:0]]) <<< 8;
  end

  assign output_bits = OUT_W'(out_st);
  assign hidden_bits = HID_W'(hid_st);

endmodule
`default_nettype wire

// File: rtl/binary_threshold_recurrent_net_step_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_threshold_recurrent_net_step_core
// Command-driven binary threshold recurrent network.
// ----------------------------------------------------------------------------
// Every command gives one result transaction. The back end takes a write
// command from the two-entry queue when it is idle with no result waiting,
// and offers its result in the cycle after it takes it. A step command
// walks every weight once through one shared multiply-accumulate unit, one
// weight per cycle, then drains the read pipeline before it offers its
// result. The back end takes no command while a result waits, so commands
// run one at a time; the queue holds up to two more commands meanwhile.
module binary_threshold_recurrent_net_step_core #(
  parameter int NUM_INPUTS  = btrn_pkg::DEF_NUM_INPUTS,
  parameter int NUM_HIDDEN  = btrn_pkg::DEF_NUM_HIDDEN,
  parameter int NUM_OUTPUTS = btrn_pkg::DEF_NUM_OUTPUTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [btrn_pkg::CMD_W-1:0]        cmd,
  input  wire logic [btrn_pkg::IDX_W-1:0]        row_index,
  input  wire logic [btrn_pkg::IDX_W-1:0]        col_index,
  input  wire logic signed [btrn_pkg::VAL_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [btrn_pkg::OUT_W-1:0]             output_bits,
  output logic [btrn_pkg::HID_W-1:0]             hidden_bits,
  output logic                                   status
);
  import btrn_pkg::*;

  item_t q_item;
  logic  q_valid, q_ready;

  btrn_front #(.NUM_INPUTS(NUM_INPUTS), .NUM_HIDDEN(NUM_HIDDEN),
               .NUM_OUTPUTS(NUM_OUTPUTS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .row_index, .col_index, .value,
    .q_valid, .q_ready, .q_item
  );

  btrn_back #(.NUM_INPUTS(NUM_INPUTS), .NUM_HIDDEN(NUM_HIDDEN),
              .NUM_OUTPUTS(NUM_OUTPUTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .output_bits, .hidden_bits, .status
  );

  // The back takes no command while a result waits.
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready) else $error("command taken while result pending");

  // A step always reports status zero.
  a_step_ok: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_item.cmd == CMD_STEP) |=> !status)
    else $error("step reported error status");

endmodule
`default_nettype wire

// File: tb/sv/tb_binary_threshold_recurrent_net_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_threshold_recurrent_net_step_core
// Drives write and step commands into the recurrent threshold network core,
// with random bursts on the command side and random stalls on the result
// side. A local predictor of the weights, thresholds, inputs and node states
// works out each result, and a monitor compares every result transaction with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_binary_threshold_recurrent_net_step_core;
  import btrn_pkg::*;

  localparam int N_IN  = DEF_NUM_INPUTS;
  localparam int N_HID = DEF_NUM_HIDDEN;
  localparam int N_OUT = DEF_NUM_OUTPUTS;

  typedef struct packed {
    logic [OUT_W-1:0] obits;
    logic [HID_W-1:0] hbits;
    logic             st;
  } net_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = CMD_STEP;
  logic [IDX_W-1:0] row_index = '0;
  logic [IDX_W-1:0] col_index = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] output_bits;
  logic [HID_W-1:0] hidden_bits;
  logic status;

  // Predictor state.
  logic signed [VAL_W-1:0] w_i2h [N_IN][N_HID];
  logic signed [VAL_W-1:0] w_h2h [N_HID][N_HID];
  logic signed [VAL_W-1:0] w_h2o [N_HID][N_OUT];
  logic signed [VAL_W-1:0] thr_hid [N_HID];
  logic signed [VAL_W-1:0] thr_out [N_OUT];
  logic signed [VAL_W-1:0] in_vals [N_IN];
  logic [N_HID-1:0] hid_state;
  logic [N_OUT-1:0] out_state;

  net_result_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_steps = 0;
  int n_rejected = 0;

  binary_threshold_recurrent_net_step_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .row_index(row_index), .col_index(col_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .output_bits(output_bits), .hidden_bits(hidden_bits), .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // Compute one network step from the old hidden state.
  function automatic void network_step();
    logic [N_HID-1:0] old_hid;
    logic [N_HID-1:0] new_hid;
    logic [N_OUT-1:0] new_out;
    logic signed [ACC_W-1:0] acc;
    old_hid = hid_state;
    new_hid = '0;
    new_out = '0;
    for (int i = 0; i < N_OUT; i++) begin
      acc = '0;
      for (int j = 0; j < N_HID; j++)
        if (old_hid[j]) acc += ACC_W'(w_h2o[j][i]);
      new_out[i] = acc > ACC_W'(thr_out[i]);
    end
    for (int i = 0; i < N_HID; i++) begin
      acc = '0;
      for (int j = 0; j < N_IN; j++)
        acc += ACC_W'(in_vals[j]) * ACC_W'(w_i2h[j][i]);
      for (int j = 0; j < N_HID; j++)
        if (old_hid[j]) acc += ACC_W'(w_h2h[j][i]) <<< 8;
      new_hid[i] = acc > (ACC_W'(thr_hid[i]) <<< 8);
    end
    out_state = new_out;
    hid_state = new_hid;
  endfunction

  // Apply one command to the predictor and return the expected result.
  function automatic net_result_t predict_command(cmd_t c, int r, int k,
                                                  logic signed [VAL_W-1:0] v);
    net_result_t res;
    res.st = 1'b0;
    case (c)
      CMD_I2H: if (r < N_IN && k < N_HID) w_i2h[r][k] = v; else res.st = 1'b1;
      CMD_H2H: if (r < N_HID && k < N_HID) w_h2h[r][k] = v; else res.st = 1'b1;
      CMD_H2O: if (r < N_HID && k < N_OUT) w_h2o[r][k] = v; else res.st = 1'b1;
      CMD_HTH: if (r < N_HID) thr_hid[r] = v; else res.st = 1'b1;
      CMD_OTH: if (r < N_OUT) thr_out[r] = v; else res.st = 1'b1;
      CMD_INP: if (r < N_IN) in_vals[r] = v; else res.st = 1'b1;
      CMD_HBIT: if (r < N_HID) hid_state[r] = v[0]; else res.st = 1'b1;
      default: network_step();
    endcase
    res.obits = OUT_W'(out_state);
    res.hbits = HID_W'(hid_state);
    return res;
  endfunction

  // Send one command transaction; valid stays high across back-to-back items.
  task automatic send_command(cmd_t c, int r, int k, logic signed [VAL_W-1:0] v);
    net_result_t res;
    in_valid <= 1'b1;
    cmd <= c;
    row_index <= IDX_W'(r);
    col_index <= IDX_W'(k);
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_command(c, r, k, v);
    pending_results = {pending_results, res};
    n_sent++;
    if (c == CMD_STEP) n_steps++;
    if (res.st) n_rejected++;
    // End of a burst: drop valid for a random gap.
    if ($urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver stall pattern: randomly switching calm and stalling phases.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) phase = $urandom_range(0, 2);
      case (phase)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker.
  initial begin
    net_result_t exp_res;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          n_checked++;
          if (output_bits !== exp_res.obits) begin
            $error("output_bits expected %h actual %h", exp_res.obits, output_bits);
            errors++;
          end
          if (hidden_bits !== exp_res.hbits) begin
            $error("hidden_bits expected %h actual %h", exp_res.hbits, hidden_bits);
            errors++;
          end
          if (status !== exp_res.st) begin
            $error("status expected %b actual %b", exp_res.st, status);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return VAL_W'($urandom_range(0, 1023)) - 16'sd512;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Write every weight and threshold so no step reads an unwritten entry.
  task automatic load_all_stores(bit extreme);
    for (int r = 0; r < N_IN; r++)
      for (int k = 0; k < N_HID; k++)
        send_command(CMD_I2H, r, k, extreme ? rand_value() : VAL_W'($urandom_range(0, 511)) - 16'sd256);
    for (int r = 0; r < N_HID; r++)
      for (int k = 0; k < N_HID; k++)
        send_command(CMD_H2H, r, k, extreme ? rand_value() : VAL_W'($urandom_range(0, 511)) - 16'sd256);
    for (int r = 0; r < N_HID; r++)
      for (int k = 0; k < N_OUT; k++)
        send_command(CMD_H2O, r, k, extreme ? rand_value() : VAL_W'($urandom_range(0, 511)) - 16'sd256);
    for (int r = 0; r < N_HID; r++)
      send_command(CMD_HTH, r, 0, VAL_W'($urandom_range(0, 511)) - 16'sd256);
    for (int r = 0; r < N_OUT; r++)
      send_command(CMD_OTH, r, 0, VAL_W'($urandom_range(0, 511)) - 16'sd256);
  endtask

  // Directed: out-of-range rows and columns, inputs, hidden bits, steps.
  task automatic test_directed();
    send_command(CMD_I2H, N_IN, 0, 16'sh7fff);
    send_command(CMD_I2H, 0, 15, 16'sh8000);
    send_command(CMD_H2H, 15, 0, 16'sd1);
    send_command(CMD_H2O, 0, N_OUT, 16'sd1);
    send_command(CMD_HTH, 15, 0, 16'sd0);
    send_command(CMD_OTH, N_OUT, 0, 16'sd0);
    send_command(CMD_INP, 15, 0, 16'sd0);
    send_command(CMD_HBIT, N_HID, 0, 16'sd1);
    send_command(CMD_INP, 0, 15, 16'sh7fff);
    send_command(CMD_INP, 3, 0, 16'sh8000);
    send_command(CMD_HBIT, 0, 9, 16'shfffe);
    send_command(CMD_HBIT, 7, 0, 16'sh0001);
    load_all_stores(1'b1);
    send_command(CMD_STEP, 0, 0, 16'sd0);
    send_command(CMD_STEP, 15, 15, 16'shffff);
    idle_input();
  endtask

  // Random: mostly valid writes with steps mixed in, plus out-of-range noise.
  task automatic test_random(int count);
    int r, k, sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, N_HID - 1);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, N_HID - 1);
      if (sel < 15) send_command(CMD_STEP, $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
      else if (sel < 25) send_command(CMD_HBIT, r, k, VAL_W'($urandom));
      else if (sel < 35) send_command(CMD_INP, r % 8, k, rand_value());
      else send_command(cmd_t'($urandom_range(0, 4)), r, k, rand_value());
    end
    idle_input();
  endtask

  initial begin
    for (int i = 0; i < N_IN; i++) in_vals[i] = '0;
    hid_state = '1;
    out_state = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    load_all_stores(1'b0);
    test_random(550);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d commands, %0d steps, %0d rejected writes; %0d results checked.",
             n_sent, n_steps, n_rejected, n_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/btrn_pkg.sv
rtl/btrn_front.sv
rtl/btrn_back.sv
rtl/binary_threshold_recurrent_net_step_core.sv
tb/sv/tb_binary_threshold_recurrent_net_step_core.sv
